### hw/rtl/fupd_pkg.sv
`timescale 1ns / 1ps
// Types, constants and helper functions shared by the file URI decoder.
package fupd_pkg;

   localparam int unsigned PREFIX_LEN = 7;
   localparam int unsigned POS_WIDTH  = $clog2(PREFIX_LEN + 1);

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] DIGIT_TEN    = 8'd10;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FILE  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   typedef enum logic [1:0] {
      ESC_IDLE,
      ESC_HIGH,
      ESC_LOW
   } esc_phase_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       terminator;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_marker;
      logic [1:0] status;
   } rsp_type;

   function automatic logic [7:0] prefix_char(input logic [POS_WIDTH-1:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h66;
         3'd1:    c = 8'h69;
         3'd2:    c = 8'h6C;
         3'd3:    c = 8'h65;
         3'd4:    c = 8'h3A;
         3'd5:    c = 8'h2F;
         3'd6:    c = 8'h2F;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Bit 4 set means the character is not a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] diff;
      logic [4:0] d;
      diff = 8'h00;
      d    = 5'h10;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - CHAR_ZERO;
         d    = {1'b0, diff[3:0]};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         diff = c - (CHAR_LOWER_A - DIGIT_TEN);
         d    = {1'b0, diff[3:0]};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         diff = c - (CHAR_UPPER_A - DIGIT_TEN);
         d    = {1'b0, diff[3:0]};
      end
      return d;
   endfunction

endpackage

### hw/rtl/fupd_in_stage.sv
`timescale 1ns / 1ps
// Input register stage of the file URI decoder.
module fupd_in_stage import fupd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    advance,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    take;

   assign req_ready  = !valid_ff || advance;
   assign take       = req_valid && req_ready;
   assign valid_in   = take || (valid_ff && !advance);
   assign item_valid = valid_ff;
   assign item       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_data;
      end
   end

endmodule

### hw/rtl/fupd_decode.sv
`timescale 1ns / 1ps
// Prefix match, escape decoding and string state of the file URI decoder.
module fupd_decode import fupd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type item,
   input  logic    fire,
   output logic    has_result,
   output rsp_type result
);

   logic [POS_WIDTH-1:0] prefix_pos_ff;
   logic [POS_WIDTH-1:0] prefix_pos_in;
   logic                 rejected_ff;
   logic                 rejected_in;
   esc_phase_type        esc_phase_ff;
   esc_phase_type        esc_phase_in;
   logic [3:0]           high_nibble_ff;
   logic [3:0]           high_nibble_in;
   logic [4:0]           digit;
   logic                 prefix_done;

   assign digit       = hex_digit(item.char_in);
   assign prefix_done = (prefix_pos_ff == POS_WIDTH'(PREFIX_LEN));

   always_comb begin
      prefix_pos_in  = prefix_pos_ff;
      rejected_in    = rejected_ff;
      esc_phase_in   = esc_phase_ff;
      high_nibble_in = high_nibble_ff;
      has_result     = 1'b0;
      result         = '0;
      if (item.terminator) begin
         has_result        = 1'b1;
         result.end_marker = 1'b1;
         if (rejected_ff || !prefix_done) begin
            result.status = STATUS_NOT_FILE;
         end else if (esc_phase_ff != ESC_IDLE) begin
            result.status = STATUS_TRUNCATED;
         end else begin
            result.status = STATUS_OK;
         end
         prefix_pos_in  = '0;
         rejected_in    = 1'b0;
         esc_phase_in   = ESC_IDLE;
         high_nibble_in = 4'h0;
      end else if (rejected_ff) begin
         has_result = 1'b0;
      end else if (!prefix_done) begin
         if (item.char_in == prefix_char(prefix_pos_ff)) begin
            prefix_pos_in = prefix_pos_ff + 1'b1;
         end else begin
            rejected_in = 1'b1;
         end
      end else begin
         case (esc_phase_ff)
            ESC_HIGH: begin
               high_nibble_in = digit[4] ? 4'hF : digit[3:0];
               esc_phase_in   = ESC_LOW;
            end
            ESC_LOW: begin
               esc_phase_in    = ESC_IDLE;
               has_result      = 1'b1;
               result.out_byte = digit[4] ? 8'hFF : {high_nibble_ff, digit[3:0]};
            end
            ESC_IDLE: begin
               if (item.char_in == CHAR_PERCENT) begin
                  esc_phase_in = ESC_HIGH;
               end else begin
                  has_result      = 1'b1;
                  result.out_byte = (item.char_in == CHAR_PLUS) ? CHAR_SPACE : item.char_in;
               end
            end
            default: begin
               esc_phase_in = ESC_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_pos_ff  <= '0;
         rejected_ff    <= 1'b0;
         esc_phase_ff   <= ESC_IDLE;
         high_nibble_ff <= 4'h0;
      end else if (fire) begin
         prefix_pos_ff  <= prefix_pos_in;
         rejected_ff    <= rejected_in;
         esc_phase_ff   <= esc_phase_in;
         high_nibble_ff <= high_nibble_in;
      end
   end

   a_reject_no_escape: assert property (@(posedge clock) disable iff (reset)
      rejected_ff |-> (esc_phase_ff == ESC_IDLE))
      else $error("escape open in a rejected string");

   a_escape_after_prefix: assert property (@(posedge clock) disable iff (reset)
      (esc_phase_ff != ESC_IDLE) |-> (prefix_done && !rejected_ff))
      else $error("escape open before prefix matched");

   a_reject_before_done: assert property (@(posedge clock) disable iff (reset)
      rejected_ff |-> !prefix_done)
      else $error("rejected after full prefix match");

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && item.terminator) |=>
         (prefix_pos_ff == '0 && !rejected_ff && esc_phase_ff == ESC_IDLE))
      else $error("state not cleared after terminator");

   a_term_result: assert property (@(posedge clock) disable iff (reset)
      item.terminator |-> (has_result && result.end_marker && result.out_byte == 8'h00))
      else $error("terminator without end result");

endmodule

### hw/rtl/fupd_out_stage.sv
`timescale 1ns / 1ps
// Result register stage of the file URI decoder.
module fupd_out_stage import fupd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

### hw/rtl/file_uri_percent_decoder.sv
`timescale 1ns / 1ps
// Top level of the file URI decoder: input register, decode stage, result register.
//
// Accepts one URI character per cycle and emits the decoded path bytes of a
// file:// URI; a terminator transaction closes each string and yields an end
// result with status (ok, not a file URI, truncated escape). The prefix, the
// percent sign and first digit of an escape and the characters of a rejected
// string produce no result. Throughput is one transaction per cycle, set by the
// single decode stage between the input and result registers. Backpressure on
// the result side stalls the input only when the pending transaction would
// produce a result and the result register is full and not being read.
module file_uri_percent_decoder import fupd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    item_valid;
   req_type item;
   logic    has_result;
   rsp_type result;
   logic    out_free;
   logic    advance;

   assign advance = item_valid && (!has_result || out_free);

   fupd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   fupd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .fire       (advance),
      .has_result (has_result),
      .result     (result)
   );

   fupd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && has_result),
      .load_data (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
